[design/indexed_insert_remove_list_core_assert.svh]
// Assertion macros shared by the list checker.
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IIRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IIRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/iirl_pkg.sv]
// Types and constants of the indexed insert/remove list.
package iirl_pkg;

	localparam int DEFAULT_DEPTH      = 16;
	localparam int DEFAULT_ELEM_WIDTH = 32;

	// Cell positions cover the largest supported depth (256).
	localparam int CELL_POS_W = 8;

	typedef enum logic [2:0] {
		ACT_APPEND    = 3'd0,
		ACT_INSERT    = 3'd1,
		ACT_READ      = 3'd2,
		ACT_OVERWRITE = 3'd3,
		ACT_REMOVE    = 3'd4,
		ACT_FIND      = 3'd5,
		ACT_CLEAR     = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} fsm_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic                  wr;
		logic [CELL_POS_W-1:0] pos;
	} cell_cmd_t;

	// Result of a find scan.
	typedef struct packed {
		logic                  done;
		logic                  found;
		logic [CELL_POS_W-1:0] pos;
	} scan_res_t;

endpackage

[design/iirl_cell.sv]
// One list cell: holds an entry, shifts with its neighbors, compares for find.
module iirl_cell #(
	parameter int ELEM_WIDTH = iirl_pkg::DEFAULT_ELEM_WIDTH,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  iirl_pkg::cell_cmd_t   cmd,
	input  logic [ELEM_WIDTH-1:0] value,
	input  logic [ELEM_WIDTH-1:0] left,
	input  logic [ELEM_WIDTH-1:0] right,
	output logic [ELEM_WIDTH-1:0] entry,
	output logic                  match
);

	localparam logic [iirl_pkg::CELL_POS_W-1:0] MY_POS = iirl_pkg::CELL_POS_W'(INDEX);

	logic [ELEM_WIDTH-1:0] entry_q;
	logic                  at_pos;
	logic                  after_pos;

	assign at_pos    = (cmd.pos == MY_POS);
	assign after_pos = (cmd.pos < MY_POS);

	always_ff @(posedge clk) begin
		if (cmd.ins && at_pos) begin
			entry_q <= value;
		end else if (cmd.ins && after_pos) begin
			entry_q <= left;
		end else if (cmd.del && (at_pos || after_pos)) begin
			entry_q <= right;
		end else if (cmd.wr && at_pos) begin
			entry_q <= value;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == value);

endmodule

[design/iirl_scan.sv]
// Find scan: registers the match row and walks it eight positions a cycle.
module iirl_scan #(
	parameter int DEPTH = iirl_pkg::DEFAULT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DEPTH-1:0]      match,
	output iirl_pkg::scan_res_t   res
);

	localparam int NCHUNK  = (DEPTH + 7) / 8;
	localparam int VEC_W   = NCHUNK * 8;
	localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic [VEC_W-1:0]   vec_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic               busy_q;
	logic               hit;
	logic               last;
	logic [2:0]         pe;

	assign hit  = |vec_q[7:0];
	assign last = (chunk_q == CHUNK_W'(NCHUNK - 1));

	// Lowest set bit of the current chunk.
	always_comb begin
		pe = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (vec_q[k]) begin
				pe = 3'(k);
			end
		end
	end

	always_comb begin
		res.done  = busy_q && (hit || last);
		res.found = hit;
		res.pos   = hit ? iirl_pkg::CELL_POS_W'({chunk_q, pe}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (res.done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			vec_q   <= VEC_W'(match);
			chunk_q <= '0;
		end else if (busy_q) begin
			vec_q   <= vec_q >> 8;
			chunk_q <= chunk_q + 1'b1;
		end
	end

endmodule

[design/indexed_insert_remove_list_core.sv]
// Indexed insert/remove list: a row of shifting cells plus a find scanner.
//
// Input stream (s_*): one request per transaction, tdata = action, position,
// value. Output stream (m_*): one result per request, tdata = status, data,
// found, found_position, count, empty_res.
// Append, insert, read, overwrite, remove and clear finish in the cycle of
// acceptance: every cell loads its own value, its left or right neighbor at
// the same clock edge, and the output register holds the result from the
// next cycle. Back-to-back requests of these kinds run at one per cycle
// while the output is not stalled. Find registers the compare row of all
// cells, then scans it eight entries a cycle; the result goes to the output
// register when the scan ends, and no request is taken meanwhile.
// Reset clears the entry count and the output valid; entry contents stay
// undefined until written and are never shown.
// While a result is stalled (m_tvalid high, m_tready low) the output holds
// and s_tready stays low; a transaction is taken in the cycle the result
// leaves.
module indexed_insert_remove_list_core #(
	parameter int DEPTH      = iirl_pkg::DEFAULT_DEPTH,
	parameter int ELEM_WIDTH = iirl_pkg::DEFAULT_ELEM_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action[2:0], position[7:3], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], data[33:2], found[34],
	                               // found_position[38:35], count[43:39],
	                               // empty_res[44], zero fill[47:45]
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = iirl_pkg::CELL_POS_W + 1;
	// Only the first 32 positions can be named by the position field.
	localparam int RD_N  = (DEPTH < 32) ? DEPTH : 32;
	localparam int RD_W  = $clog2(RD_N);

	// Request fields
	iirl_pkg::act_t        act;
	logic [4:0]            position;
	logic [ELEM_WIDTH-1:0] val;

	assign act      = iirl_pkg::act_t'(s_tdata[2:0]);
	assign position = s_tdata[7:3];
	assign val      = ELEM_WIDTH'(s_tdata[39:8]);

	// Control
	iirl_pkg::fsm_t      state_q, state_d;
	logic                s_fire;
	logic                scan_start;
	iirl_pkg::scan_res_t scan_res;

	// Cell row
	iirl_pkg::cell_cmd_t   cmd;
	logic [ELEM_WIDTH-1:0] cell_entry [DEPTH];
	logic [DEPTH-1:0]      cell_match;
	logic [DEPTH-1:0]      match_v;
	logic [ELEM_WIDTH-1:0] rd_arr [2**RD_W];

	// Count and result
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [CMP_W-1:0]      cnt_x, pos_x, ins_x;
	logic                  out_load;
	logic                  out_valid_q;
	iirl_pkg::status_t     res_status, status_q;
	logic [31:0]           res_data, data_q;
	logic                  res_found, found_q;
	logic [3:0]            res_fpos, fpos_q;

	assign s_fire = s_tvalid && s_tready;
	assign cnt_x  = CMP_W'(cnt_q);
	assign pos_x  = CMP_W'(position);

	// Cells: position 0 takes nothing from the left, the last cell keeps
	// itself on a remove.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_in;
		logic [ELEM_WIDTH-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in = cell_entry[i];
		end else begin : g_mid_r
			assign right_in = cell_entry[i+1];
		end

		iirl_cell #(
			.ELEM_WIDTH(ELEM_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.value(val),
			.left (left_in),
			.right(right_in),
			.entry(cell_entry[i]),
			.match(cell_match[i])
		);

		// Only live entries may match.
		assign match_v[i] = cell_match[i] && (CNT_W'(i) < cnt_q);
	end

	// Read port over the addressable positions, padded to a power of two.
	for (genvar r = 0; r < 2**RD_W; r++) begin : g_rd
		if (r < RD_N) begin : g_live
			assign rd_arr[r] = cell_entry[r];
		end else begin : g_pad
			assign rd_arr[r] = '0;
		end
	end

	iirl_scan #(
		.DEPTH(DEPTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.match (match_v),
		.res   (scan_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iirl_pkg::FSM_IDLE: begin
				if (s_fire && act == iirl_pkg::ACT_FIND) begin
					state_d = iirl_pkg::FSM_SCAN;
				end
			end
			iirl_pkg::FSM_SCAN: begin
				if (scan_res.done) begin
					state_d = iirl_pkg::FSM_IDLE;
				end
			end
			default: state_d = iirl_pkg::FSM_IDLE;
		endcase
	end

	// State outputs: take a request only when idle and the output slot frees.
	always_comb begin
		s_tready   = 1'b0;
		scan_start = 1'b0;
		unique case (state_q)
			iirl_pkg::FSM_IDLE: begin
				s_tready   = !out_valid_q || m_tready;
				scan_start = s_tvalid && (!out_valid_q || m_tready) &&
				             (act == iirl_pkg::ACT_FIND);
			end
			iirl_pkg::FSM_SCAN: begin
				s_tready   = 1'b0;
				scan_start = 1'b0;
			end
			default: begin
				s_tready   = 1'b0;
				scan_start = 1'b0;
			end
		endcase
	end

	// Request decode: cell command, new count and result fields.
	always_comb begin
		cmd        = '0;
		cnt_d      = cnt_q;
		res_status = iirl_pkg::ST_OK;
		res_data   = '0;
		res_found  = 1'b0;
		res_fpos   = '0;
		out_load   = 1'b0;
		ins_x      = (act == iirl_pkg::ACT_APPEND) ? cnt_x : pos_x;

		if (state_q == iirl_pkg::FSM_SCAN) begin
			// Finish a find: count is untouched.
			out_load  = scan_res.done;
			res_found = scan_res.found;
			res_fpos  = scan_res.pos[3:0];
		end else if (s_fire) begin
			out_load = (act != iirl_pkg::ACT_FIND);
			unique case (act) inside
				iirl_pkg::ACT_APPEND, iirl_pkg::ACT_INSERT: begin
					if (ins_x > cnt_x) begin
						res_status = iirl_pkg::ST_BADPOS;
					end else if (cnt_x == CMP_W'(DEPTH)) begin
						res_status = iirl_pkg::ST_FULL;
					end else begin
						cmd.ins = 1'b1;
						cmd.pos = iirl_pkg::CELL_POS_W'(ins_x);
						cnt_d   = cnt_q + 1'b1;
					end
				end
				iirl_pkg::ACT_READ, iirl_pkg::ACT_OVERWRITE,
				iirl_pkg::ACT_REMOVE: begin
					cmd.pos = iirl_pkg::CELL_POS_W'(position);
					if (pos_x >= cnt_x) begin
						res_status = iirl_pkg::ST_BADPOS;
					end else if (act == iirl_pkg::ACT_OVERWRITE) begin
						cmd.wr = 1'b1;
					end else begin
						res_data = 32'(rd_arr[position[RD_W-1:0]]);
						if (act == iirl_pkg::ACT_REMOVE) begin
							cmd.del = 1'b1;
							cnt_d   = cnt_q - 1'b1;
						end
					end
				end
				iirl_pkg::ACT_CLEAR: begin
					cnt_d = '0;
				end
				default: begin
					// Find starts the scan; unused codes leave the list alone.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iirl_pkg::FSM_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status;
			data_q   <= res_data;
			found_q  <= res_found;
			fpos_q   <= res_fpos;
		end
	end

	// Count and empty come straight from the live count: no request is taken
	// while a result waits, so it always matches the shown result.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, (cnt_q == '0), 5'(cnt_q), fpos_q, found_q, data_q,
	                   status_q};

endmodule

[design/iirl_checker.sv]
// Port-level checker for the list core, bound to the top level.
`include "indexed_insert_remove_list_core_assert.svh"

module iirl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	logic out_stall;
	logic status_ok;
	logic rejected;
	logic found_seen;

	assign out_stall  = m_tvalid && !m_tready;
	assign status_ok  = (m_tdata[1:0] == iirl_pkg::ST_OK);
	assign rejected   = m_tvalid && !status_ok;
	assign found_seen = m_tvalid && m_tdata[34];

	`IIRL_ASSERT_NEXT(a_stall_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")
	`IIRL_ASSERT_NOW(a_stall_blocks_in, out_stall, !s_tready, "request taken while result stalled")
	`IIRL_ASSERT_NOW(a_reject_no_data, rejected, m_tdata[33:2] == 32'd0, "rejected request data")
	`IIRL_ASSERT_NOW(a_found_live, found_seen, status_ok && !m_tdata[44], "match on bad or empty")

endmodule

bind indexed_insert_remove_list_core iirl_checker u_iirl_checker (.*);
